// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

	localparam int REQ_W       = 2;
	localparam int VALUE_W     = 32;
	localparam int PRIO_FLD_W  = 8;
	localparam int STATUS_W    = 2;
	localparam int POS_FLD_W   = 4;
	localparam int OCC_FLD_W   = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'b01,
		FSM_SEARCH = 2'b10
	} fsm_state_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_cmd_t;

endpackage

// ----- rtl/core/spq_req_if.sv -----
// Request channel: valid/ready handshake with insert, remove and search payload.
interface spq_req_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [VALUE_W-1:0] element_value;
	logic [PRIO_FLD_W-1:0]     priority_req;

	modport source (output valid, req_type, element_value, priority_req, input ready);
	modport sink   (input valid, req_type, element_value, priority_req, output ready);
endinterface

// ----- rtl/core/spq_rsp_if.sv -----
// Response channel: valid/ready handshake with status and entry payload.
interface spq_rsp_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] value_out;
	logic [PRIO_FLD_W-1:0]     priority_out;
	logic [POS_FLD_W-1:0]      position;
	logic [OCC_FLD_W-1:0]      occupancy;

	modport source (output valid, status, value_out, priority_out, position, occupancy,
		input ready);
	modport sink   (input valid, status, value_out, priority_out, position, occupancy,
		output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
// One queue slot: holds an entry and shifts it toward the head or tail.
module spq_cell import spq_pkg::*; #(
	parameter int PRIO_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_cmd_t                 cmd,
	input  logic signed [VALUE_W-1:0] new_value,
	input  logic [PRIO_BITS-1:0]      new_prio,
	input  logic                      left_ins,
	input  logic                      left_valid,
	input  logic signed [VALUE_W-1:0] left_value,
	input  logic [PRIO_BITS-1:0]      left_prio,
	input  logic                      right_valid,
	input  logic signed [VALUE_W-1:0] right_value,
	input  logic [PRIO_BITS-1:0]      right_prio,
	output logic                      valid,
	output logic signed [VALUE_W-1:0] value,
	output logic [PRIO_BITS-1:0]      prio,
	output logic                      ins
);

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [PRIO_BITS-1:0]      prio_q;

	assign ins   = !valid_q || (prio_q > new_prio);
	assign valid = valid_q;
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shl) begin
			valid_q <= right_valid;
		end else if (cmd.ins) begin
			if (left_ins) begin
				valid_q <= left_valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shl) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end else if (cmd.ins) begin
			if (left_ins) begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end else if (ins) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end
		end
	end

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
// Stable priority queue top level: cell chain, request control and response register.
//
// Entries sit in a chain of DEPTH cells kept in ascending priority order, ties in
// arrival order. For insert, remove and unused request codes the item is accepted
// and its response is loaded into the output register at the same edge. A search
// rotates the chain one place per cycle until every entry has passed the head
// cell, where it is compared with the key, and the full rotation leaves the order
// as it was. A new request is accepted when no search is running and the output
// register is empty or being read in that cycle.
module stable_priority_queue import spq_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int PRIO_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);

	function automatic logic [PRIO_BITS-1:0] prio_in(input logic [PRIO_FLD_W-1:0] p);
		logic [PRIO_BITS-1:0] r;
		r = '0;
		for (int b = 0; b < PRIO_BITS && b < PRIO_FLD_W; b++) r[b] = p[b];
		return r;
	endfunction

	function automatic logic [PRIO_FLD_W-1:0] prio_out(input logic [PRIO_BITS-1:0] p);
		logic [PRIO_FLD_W-1:0] r;
		r = '0;
		for (int b = 0; b < PRIO_BITS && b < PRIO_FLD_W; b++) r[b] = p[b];
		return r;
	endfunction

	function automatic logic [POS_FLD_W-1:0] pos_out(input logic [SW-1:0] p);
		logic [POS_FLD_W-1:0] r;
		r = '0;
		for (int b = 0; b < SW && b < POS_FLD_W; b++) r[b] = p[b];
		return r;
	endfunction

	function automatic logic [OCC_FLD_W-1:0] occ_out(input logic [CW-1:0] c);
		logic [OCC_FLD_W-1:0] r;
		r = '0;
		for (int b = 0; b < CW && b < OCC_FLD_W; b++) r[b] = c[b];
		return r;
	endfunction

	fsm_state_t                state_q;
	logic [CW-1:0]             count_q;
	logic [SW-1:0]             step_q;
	logic signed [VALUE_W-1:0] key_q;
	logic                      found_q;
	logic signed [VALUE_W-1:0] fvalue_q;
	logic [PRIO_BITS-1:0]      fprio_q;
	logic [SW-1:0]             fpos_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [PRIO_FLD_W-1:0]     out_prio_q;
	logic [POS_FLD_W-1:0]      out_pos_q;
	logic [OCC_FLD_W-1:0]      out_occ_q;

	logic                      accept;
	logic                      is_full;
	logic                      is_empty;
	logic                      hit;
	logic                      last_step;
	logic [PRIO_BITS-1:0]      new_prio;
	cell_cmd_t                 cmd;

	logic                      c_valid [DEPTH];
	logic signed [VALUE_W-1:0] c_value [DEPTH];
	logic [PRIO_BITS-1:0]      c_prio  [DEPTH];
	logic                      c_ins   [DEPTH];

	assign req.ready = (state_q == FSM_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign new_prio  = prio_in(req.priority_req);
	assign hit       = c_valid[0] && (c_value[0] == key_q) && !found_q;
	assign last_step = (step_q == SW'(DEPTH - 1));

	always_comb begin
		cmd.ins = accept && (req.req_type == REQ_INSERT) && !is_full;
		cmd.shl = (accept && (req.req_type == REQ_REMOVE) && !is_empty)
			|| (state_q == FSM_SEARCH);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      l_ins;
		logic                      l_valid;
		logic signed [VALUE_W-1:0] l_value;
		logic [PRIO_BITS-1:0]      l_prio;
		logic                      r_valid;
		logic signed [VALUE_W-1:0] r_value;
		logic [PRIO_BITS-1:0]      r_prio;

		if (i == 0) begin : g_head
			assign l_ins   = 1'b0;
			assign l_valid = 1'b0;
			assign l_value = '0;
			assign l_prio  = '0;
		end else begin : g_body
			assign l_ins   = c_ins[i-1];
			assign l_valid = c_valid[i-1];
			assign l_value = c_value[i-1];
			assign l_prio  = c_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid = (state_q == FSM_SEARCH) && c_valid[0];
			assign r_value = c_value[0];
			assign r_prio  = c_prio[0];
		end else begin : g_inner
			assign r_valid = c_valid[i+1];
			assign r_value = c_value[i+1];
			assign r_prio  = c_prio[i+1];
		end

		spq_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_value   (req.element_value),
			.new_prio    (new_prio),
			.left_ins    (l_ins),
			.left_valid  (l_valid),
			.left_value  (l_value),
			.left_prio   (l_prio),
			.right_valid (r_valid),
			.right_value (r_value),
			.right_prio  (r_prio),
			.valid       (c_valid[i]),
			.value       (c_value[i]),
			.prio        (c_prio[i]),
			.ins         (c_ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((accept && req.req_type != REQ_SEARCH)
					|| (state_q == FSM_SEARCH && last_step)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_SEARCH) begin
							state_q <= FSM_SEARCH;
							step_q  <= '0;
							found_q <= 1'b0;
						end else begin
							if (cmd.ins) begin
								count_q <= count_q + 1'b1;
							end else if (req.req_type == REQ_REMOVE && !is_empty) begin
								count_q <= count_q - 1'b1;
							end
						end
					end
				end
				FSM_SEARCH: begin
					step_q <= step_q + 1'b1;
					if (hit) begin
						found_q <= 1'b1;
					end
					if (last_step) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_SEARCH) begin
			key_q <= req.element_value;
		end
		if (state_q == FSM_SEARCH && hit) begin
			fvalue_q <= c_value[0];
			fprio_q  <= c_prio[0];
			fpos_q   <= step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type != REQ_SEARCH) begin
			out_pos_q <= '0;
			case (req.req_type)
				REQ_INSERT: begin
					out_value_q <= '0;
					out_prio_q  <= '0;
					if (is_full) begin
						out_status_q <= ST_FULL;
						out_occ_q    <= occ_out(count_q);
					end else begin
						out_status_q <= ST_OK;
						out_occ_q    <= occ_out(count_q + 1'b1);
					end
				end
				REQ_REMOVE: begin
					if (is_empty) begin
						out_status_q <= ST_EMPTY;
						out_value_q  <= '0;
						out_prio_q   <= '0;
						out_occ_q    <= occ_out(count_q);
					end else begin
						out_status_q <= ST_OK;
						out_value_q  <= c_value[0];
						out_prio_q   <= prio_out(c_prio[0]);
						out_occ_q    <= occ_out(count_q - 1'b1);
					end
				end
				default: begin
					out_status_q <= ST_OK;
					out_value_q  <= '0;
					out_prio_q   <= '0;
					out_occ_q    <= occ_out(count_q);
				end
			endcase
		end else if (state_q == FSM_SEARCH && last_step) begin
			out_occ_q <= occ_out(count_q);
			if (found_q) begin
				out_status_q <= ST_OK;
				out_value_q  <= fvalue_q;
				out_prio_q   <= prio_out(fprio_q);
				out_pos_q    <= pos_out(fpos_q);
			end else if (hit) begin
				out_status_q <= ST_OK;
				out_value_q  <= c_value[0];
				out_prio_q   <= prio_out(c_prio[0]);
				out_pos_q    <= pos_out(step_q);
			end else begin
				out_status_q <= ST_NOT_FOUND;
				out_value_q  <= '0;
				out_prio_q   <= '0;
				out_pos_q    <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.value_out    = out_value_q;
	assign rsp.priority_out = out_prio_q;
	assign rsp.position     = out_pos_q;
	assign rsp.occupancy    = out_occ_q;

endmodule
